FILE: src/multi_window_moving_average_assert.svh
// assertion macros shared by the moving average block
`ifndef MULTI_WINDOW_MOVING_AVERAGE_ASSERT_SVH
`define MULTI_WINDOW_MOVING_AVERAGE_ASSERT_SVH

// same-cycle implication, masked during reset
`define MWMA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("mwma check failed");

// next-cycle implication, masked during reset
`define MWMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("mwma check failed");

`endif

FILE: src/mwma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mwma_pkg;

	localparam int MAX_WINDOW  = 256;
	localparam int NUM_WINDOWS = 4;
	localparam int FRAC_BITS   = 8;

	// fixed by the register map and the result beat
	localparam int NUM_REGS = 4;
	localparam int SAMPLE_W = 32;
	localparam int PER_W    = 9;
	localparam int AVG_W    = 40;
	localparam int SUM_W    = 40;

	localparam int PTR_W  = $clog2(MAX_WINDOW);
	localparam int SEEN_W = $clog2(MAX_WINDOW + 1);
	localparam int HIST_W = SAMPLE_W + 1;
	localparam int WIN_W  = $clog2(NUM_REGS);

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = $clog2(NUM_REGS * 4);
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	// divider: quotient bits retired per cycle
	localparam int DVD_W     = SUM_W + FRAC_BITS;
	localparam int DIV_BITS  = 2;
	localparam int DIV_STEPS = (DVD_W + DIV_BITS - 1) / DIV_BITS;
	localparam int DVD_PAD_W = DIV_STEPS * DIV_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef logic [PER_W-1:0] period_t;

	localparam logic [REG_IDX_W-1:0] REG_PERIOD_0 = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_PERIOD_1 = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_PERIOD_2 = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_PERIOD_3 = REG_IDX_W'(3);

	localparam period_t PERIOD_0_RESET = PER_W'(5);
	localparam period_t PERIOD_1_RESET = PER_W'(20);
	localparam period_t PERIOD_2_RESET = PER_W'(60);
	localparam period_t PERIOD_3_RESET = PER_W'(120);

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		period_t          divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

FILE: src/mwma_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mwma_in_if;
	logic                          valid;
	logic                          ready;
	logic [mwma_pkg::SAMPLE_W-1:0] sample_value;
	logic                          sample_valid;

	modport source (output valid, sample_value, sample_valid, input ready);
	modport sink (input valid, sample_value, sample_valid, output ready);
endinterface

`default_nettype wire

FILE: src/mwma_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mwma_out_if;
	logic                       valid;
	logic                       ready;
	logic [mwma_pkg::AVG_W-1:0] avg_0;
	logic [mwma_pkg::AVG_W-1:0] avg_1;
	logic [mwma_pkg::AVG_W-1:0] avg_2;
	logic [mwma_pkg::AVG_W-1:0] avg_3;
	logic                       ok_0;
	logic                       ok_1;
	logic                       ok_2;
	logic                       ok_3;

	modport source (output valid, avg_0, avg_1, avg_2, avg_3, ok_0, ok_1, ok_2, ok_3,
		input ready);
	modport sink (input valid, avg_0, avg_1, avg_2, avg_3, ok_0, ok_1, ok_2, ok_3,
		output ready);
endinterface

`default_nettype wire

FILE: src/mwma_hist_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mwma_hist_ram (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [mwma_pkg::PTR_W-1:0]    waddr,
	input  wire logic [mwma_pkg::HIST_W-1:0]   wdata,
	input  wire logic                          re,
	input  wire logic [mwma_pkg::PTR_W-1:0]    raddr,
	output logic      [mwma_pkg::HIST_W-1:0]   rdata
);

	logic [mwma_pkg::HIST_W-1:0] mem_q [mwma_pkg::MAX_WINDOW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: src/mwma_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module mwma_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [mwma_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [mwma_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [mwma_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready,
	output mwma_pkg::period_t                      period [mwma_pkg::NUM_REGS]
);

	mwma_pkg::period_t                period_q [mwma_pkg::NUM_REGS];
	logic [mwma_pkg::REG_IDX_W-1:0]  idx;
	logic                            wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[mwma_pkg::APB_ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q[mwma_pkg::REG_PERIOD_0] <= mwma_pkg::PERIOD_0_RESET;
			period_q[mwma_pkg::REG_PERIOD_1] <= mwma_pkg::PERIOD_1_RESET;
			period_q[mwma_pkg::REG_PERIOD_2] <= mwma_pkg::PERIOD_2_RESET;
			period_q[mwma_pkg::REG_PERIOD_3] <= mwma_pkg::PERIOD_3_RESET;
		end else if (wr_en && (32'(idx) < mwma_pkg::NUM_REGS)) begin
			period_q[idx] <= pwdata[mwma_pkg::PER_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (32'(idx) < mwma_pkg::NUM_REGS) begin
			prdata = mwma_pkg::APB_DATA_W'(period_q[idx]);
		end
	end

	assign period = period_q;

endmodule

`default_nettype wire

FILE: src/mwma_divider.sv
`timescale 1ns / 1ps
`default_nettype none

`include "multi_window_moving_average_assert.svh"

module mwma_divider (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire mwma_pkg::div_req_t           req,
	output mwma_pkg::div_stat_t               stat,
	output logic      [mwma_pkg::AVG_W-1:0]   quotient
);

	localparam int REM_W = mwma_pkg::PER_W;

	logic [REM_W-1:0]                   rem_q;
	logic [mwma_pkg::DVD_PAD_W-1:0]     quo_q;
	mwma_pkg::period_t                  divr_q;
	logic [mwma_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic                               busy_q;
	logic                               done_q;

	logic [REM_W-1:0]                   rem_c;
	logic [mwma_pkg::DVD_PAD_W-1:0]     quo_c;
	logic [REM_W:0]                     trial;

	// restoring division, DIV_BITS quotient bits per cycle; the dividend
	// shifts out of the top of quo while quotient bits shift in at the bottom
	always_comb begin
		rem_c = rem_q;
		quo_c = quo_q;
		trial = '0;
		for (int j = 0; j < mwma_pkg::DIV_BITS; j++) begin
			trial = {rem_c, quo_c[mwma_pkg::DVD_PAD_W-1]};
			quo_c = {quo_c[mwma_pkg::DVD_PAD_W-2:0], 1'b0};
			if (trial >= {1'b0, divr_q}) begin
				trial    = trial - {1'b0, divr_q};
				quo_c[0] = 1'b1;
			end
			rem_c = trial[REM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= mwma_pkg::DIV_CNT_W'(mwma_pkg::DIV_STEPS - 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= rem_c;
			quo_q <= quo_c;
		end else if (req.start) begin
			rem_q  <= '0;
			quo_q  <= mwma_pkg::DVD_PAD_W'(req.dividend);
			divr_q <= req.divisor;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q[mwma_pkg::AVG_W-1:0];

	`MWMA_ASSERT_NEXT(a_start_busy, clk, arst_n, req.start && !busy_q, busy_q)
	`MWMA_ASSERT_NOW(a_done_idle, clk, arst_n, done_q, !busy_q)
	`MWMA_ASSERT_NEXT(a_busy_holds, clk, arst_n, busy_q && (cnt_q != '0), busy_q && !done_q)

endmodule

`default_nettype wire

FILE: src/multi_window_moving_average.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  kind          payload
// in_ch     in   valid/ready   sample_value[31:0], sample_valid
// out_ch    out  valid/ready   avg_0..avg_3[39:0], ok_0..ok_3
// apb       in   psel/penable  period_0..period_3 at 0x0, 0x4, 0x8, 0xc
//
// the ring scan covers the longest window that is enabled and filled, reading one entry
// a cycle through the single read port; then one shared radix-4 divider runs once
// per valid window, and windows that are not valid skip the divider
// reset clears pointers, fill count and handshake state; the ring is not cleared
// a result waits in the output register while the next item is taken; the
// sequencer holds at the end of an item only if the previous result is still there

`include "multi_window_moving_average_assert.svh"

module multi_window_moving_average (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	mwma_in_if.sink                                in_ch,
	mwma_out_if.source                             out_ch,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [mwma_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [mwma_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [mwma_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_DIVW = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	localparam int NR = mwma_pkg::NUM_REGS;

	mwma_pkg::period_t                  period [NR];

	logic [2:0]                         state_q;
	logic [mwma_pkg::PTR_W-1:0]         wp_q;
	logic [mwma_pkg::SEEN_W-1:0]        seen_q;
	logic [mwma_pkg::PTR_W-1:0]         rd_addr_q;
	logic [mwma_pkg::SEEN_W-1:0]        rd_issued_q;
	logic [mwma_pkg::SEEN_W-1:0]        acc_cnt_q;
	logic [mwma_pkg::SEEN_W-1:0]        scan_len_q;
	logic                               rd_pend_s1;
	logic [NR-1:0]                      en_q;
	logic [mwma_pkg::WIN_W-1:0]         win_q;
	logic [mwma_pkg::SUM_W-1:0]         sum_q;
	logic                               gap_q;
	logic [mwma_pkg::SUM_W-1:0]         snap_sum_q [NR];
	logic [NR-1:0]                      snap_ok_q;
	logic                               out_valid_q;
	logic [mwma_pkg::AVG_W-1:0]         avg_q [NR];
	logic [NR-1:0]                      ok_q;

	logic                               accept;
	logic [mwma_pkg::SEEN_W-1:0]        seen_next;
	logic [NR-1:0]                      en_c;
	logic [mwma_pkg::SEEN_W-1:0]        scan_len_c;
	logic [mwma_pkg::PTR_W-1:0]         wp_next;
	logic                               issue;
	logic [mwma_pkg::HIST_W-1:0]        rd_data;
	logic                               hist_flag;
	logic [mwma_pkg::SUM_W-1:0]         sum_c;
	logic                               gap_c;
	logic [mwma_pkg::SEEN_W-1:0]        acc_next;
	logic                               scan_end;
	logic                               win_last;
	logic                               out_load;

	mwma_pkg::div_req_t                 div_req;
	mwma_pkg::div_stat_t                div_stat;
	logic [mwma_pkg::AVG_W-1:0]         div_quo;

	mwma_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.period  (period)
	);

	mwma_hist_ram u_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_q),
		.wdata ({in_ch.sample_valid, in_ch.sample_value}),
		.re    (issue),
		.raddr (rd_addr_q),
		.rdata (rd_data)
	);

	mwma_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	assign seen_next = (32'(seen_q) < mwma_pkg::MAX_WINDOW) ? seen_q + 1'b1 : seen_q;
	assign wp_next   = (32'(wp_q) + 1 >= mwma_pkg::MAX_WINDOW) ? '0 : wp_q + 1'b1;

	// a window is live when enabled, short enough and already filled
	always_comb begin
		scan_len_c = '0;
		for (int k = 0; k < NR; k++) begin
			en_c[k] = (k < mwma_pkg::NUM_WINDOWS) && (period[k] != '0) &&
				(32'(period[k]) <= mwma_pkg::MAX_WINDOW) &&
				(32'(seen_next) >= 32'(period[k]));
			if (en_c[k] && (mwma_pkg::SEEN_W'(period[k]) > scan_len_c)) begin
				scan_len_c = mwma_pkg::SEEN_W'(period[k]);
			end
		end
	end

	assign issue     = (state_q == ST_SCAN) && (rd_issued_q < scan_len_q);
	assign hist_flag = rd_data[mwma_pkg::HIST_W-1];
	assign sum_c     = sum_q + (hist_flag ?
		mwma_pkg::SUM_W'(rd_data[mwma_pkg::SAMPLE_W-1:0]) : '0);
	assign gap_c     = gap_q || !hist_flag;
	assign acc_next  = acc_cnt_q + 1'b1;
	assign scan_end  = rd_pend_s1 && (acc_next == scan_len_q);
	assign win_last  = (win_q == mwma_pkg::WIN_W'(NR - 1));
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);

	assign div_req.start    = (state_q == ST_DIV) && snap_ok_q[win_q];
	assign div_req.dividend = mwma_pkg::DVD_W'(snap_sum_q[win_q]) << mwma_pkg::FRAC_BITS;
	assign div_req.divisor  = period[win_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			seen_q      <= '0;
			rd_issued_q <= '0;
			acc_cnt_q   <= '0;
			scan_len_q  <= '0;
			rd_pend_s1  <= 1'b0;
			en_q        <= '0;
			win_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= issue;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						wp_q        <= wp_next;
						seen_q      <= seen_next;
						en_q        <= en_c;
						scan_len_q  <= scan_len_c;
						rd_issued_q <= '0;
						acc_cnt_q   <= '0;
						state_q     <= (scan_len_c == '0) ? ST_OUT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_issued_q <= rd_issued_q + 1'b1;
					end
					if (rd_pend_s1) begin
						acc_cnt_q <= acc_next;
					end
					if (scan_end) begin
						win_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (snap_ok_q[win_q]) begin
						state_q <= ST_DIVW;
					end else if (win_last) begin
						state_q <= ST_OUT;
					end else begin
						win_q <= win_q + 1'b1;
					end
				end
				ST_DIVW: begin
					if (div_stat.done) begin
						if (win_last) begin
							state_q <= ST_OUT;
						end else begin
							win_q   <= win_q + 1'b1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan walks back from the newest slot; each window grabs the running
	// sum when its length is reached, later overwritten by its quotient if gap-free
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_addr_q <= wp_q;
			sum_q     <= '0;
			gap_q     <= 1'b0;
			snap_ok_q <= '0;
		end
		if (issue) begin
			rd_addr_q <= (rd_addr_q == '0) ?
				mwma_pkg::PTR_W'(mwma_pkg::MAX_WINDOW - 1) : rd_addr_q - 1'b1;
		end
		if ((state_q == ST_SCAN) && rd_pend_s1) begin
			sum_q <= sum_c;
			gap_q <= gap_c;
			for (int k = 0; k < NR; k++) begin
				if (en_q[k] && (acc_next == mwma_pkg::SEEN_W'(period[k]))) begin
					snap_sum_q[k] <= sum_c;
					snap_ok_q[k]  <= !gap_c;
				end
			end
		end
		if ((state_q == ST_DIVW) && div_stat.done) begin
			snap_sum_q[win_q] <= div_quo;
		end
		if (out_load) begin
			for (int k = 0; k < NR; k++) begin
				avg_q[k] <= snap_ok_q[k] ? snap_sum_q[k] : '0;
				ok_q[k]  <= snap_ok_q[k];
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.avg_0 = avg_q[0];
	assign out_ch.avg_1 = avg_q[1];
	assign out_ch.avg_2 = avg_q[2];
	assign out_ch.avg_3 = avg_q[3];
	assign out_ch.ok_0  = ok_q[0];
	assign out_ch.ok_1  = ok_q[1];
	assign out_ch.ok_2  = ok_q[2];
	assign out_ch.ok_3  = ok_q[3];

	`MWMA_ASSERT_NEXT(a_busy_after_beat, clk, arst_n, accept, !in_ch.ready)
	`MWMA_ASSERT_NOW(a_div_start_idle, clk, arst_n, div_req.start, !div_stat.busy)
	`MWMA_ASSERT_NOW(a_scan_bound, clk, arst_n, state_q == ST_SCAN, acc_cnt_q <= scan_len_q)
	`MWMA_ASSERT_NOW(a_invalid_zero, clk, arst_n, out_valid_q && !ok_q[0], avg_q[0] == '0)
	`MWMA_ASSERT_NEXT(a_out_loaded, clk, arst_n, out_load, out_valid_q && in_ch.ready)

endmodule

`default_nettype wire
